// ===== hdl/fl32cs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fl32cs_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned SUM_W      = 32;
	localparam int unsigned HALF_W     = 16;
	localparam int unsigned CHECKSUM_W = 32;

	localparam logic [SUM_W-1:0] SUM_INIT = 32'h0000_ffff;

	// one classified word between front and back
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              fold;
		logic              last;
	} cmd_t;

endpackage

`default_nettype wire

// ===== hdl/fl32cs_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fl32cs_fifo #(
	parameter int unsigned WIDTH = 10,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_ptr_q;
	logic [AW:0]      rd_ptr_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (wr_ptr_q[AW] != rd_ptr_q[AW]) &&
	               (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
	assign empty = (wr_ptr_q == rd_ptr_q);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	assign rd_data = mem_q[rd_ptr_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q[AW-1:0]] <= wr_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(full && empty))
		else $error("fifo reports full and empty together");

	assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> !empty)
		else $error("fifo empty after a write without a read");

	assert property (@(posedge clk) disable iff (!arst_n)
		(do_rd && !do_wr) |=> !full)
		else $error("fifo full after a read without a write");

endmodule

`default_nettype wire

// ===== hdl/fl32cs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fl32cs_front #(
	parameter int unsigned BLOCK_BYTES = 360
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  push,
	output logic                                       full,
	input  wire logic [fl32cs_pkg::BYTE_W-1:0]         data_byte,
	input  wire logic                                  last_byte,
	output logic                                       cmd_push,
	output fl32cs_pkg::cmd_t                           cmd,
	input  wire logic                                  cmd_full
);

	import fl32cs_pkg::*;

	localparam int unsigned CNT_W = $clog2(BLOCK_BYTES + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_BYTES - 1);

	logic [CNT_W-1:0] block_count_q;
	logic             block_end;

	assign full      = cmd_full;
	assign cmd_push  = push && !cmd_full;
	assign block_end = (block_count_q == CNT_LAST) || last_byte;

	assign cmd.data_byte = data_byte;
	assign cmd.fold      = block_end;
	assign cmd.last      = last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= '0;
		end else if (cmd_push) begin
			if (block_end) begin
				block_count_q <= '0;
			end else begin
				block_count_q <= block_count_q + 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) block_count_q <= CNT_LAST)
		else $error("block count ran past the block length");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_push && last_byte) |=> (block_count_q == '0))
		else $error("block count not cleared after the last word");

	assert property (@(posedge clk) disable iff (!arst_n) cmd_full |-> !cmd_push)
		else $error("word pushed into a full queue");

endmodule

`default_nettype wire

// ===== hdl/fl32cs_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fl32cs_accum (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire fl32cs_pkg::cmd_t                   cmd,
	input  wire logic                               cmd_empty,
	output logic                                    cmd_pop,
	output logic                                    res_push,
	output logic [fl32cs_pkg::CHECKSUM_W-1:0]       res_data,
	input  wire logic                               res_full
);

	import fl32cs_pkg::*;

	localparam int unsigned FOLD_W = HALF_W + 1;

	function automatic logic [FOLD_W-1:0] fold16(input logic [SUM_W-1:0] v);
		return FOLD_W'(v[HALF_W-1:0]) + FOLD_W'(v[SUM_W-1:HALF_W]);
	endfunction

	logic [SUM_W-1:0]  low_q;
	logic [SUM_W-1:0]  high_q;
	logic [SUM_W-1:0]  low_nxt;
	logic [SUM_W-1:0]  high_nxt;
	logic [FOLD_W-1:0] low_fold;
	logic [FOLD_W-1:0] high_fold;
	logic              fin_valid_s2;
	logic [FOLD_W-1:0] fin_low_s2;
	logic [FOLD_W-1:0] fin_high_s2;
	logic [HALF_W-1:0] out_low;
	logic [HALF_W-1:0] out_high;

	assign cmd_pop  = !cmd_empty && (!fin_valid_s2 || !res_full);
	assign res_push = fin_valid_s2 && !res_full;

	assign low_nxt   = low_q + SUM_W'(cmd.data_byte);
	assign high_nxt  = high_q + low_q + SUM_W'(cmd.data_byte);
	assign low_fold  = fold16(low_nxt);
	assign high_fold = fold16(high_nxt);

	// second fold at the end of the message
	assign out_low  = HALF_W'(FOLD_W'(fin_low_s2[HALF_W-1:0]) + FOLD_W'(fin_low_s2[HALF_W]));
	assign out_high = HALF_W'(FOLD_W'(fin_high_s2[HALF_W-1:0]) + FOLD_W'(fin_high_s2[HALF_W]));
	assign res_data = {out_high, out_low};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q        <= SUM_INIT;
			high_q       <= SUM_INIT;
			fin_valid_s2 <= 1'b0;
		end else begin
			if (cmd_pop) begin
				if (cmd.last) begin
					low_q  <= SUM_INIT;
					high_q <= SUM_INIT;
				end else if (cmd.fold) begin
					low_q  <= SUM_W'(low_fold);
					high_q <= SUM_W'(high_fold);
				end else begin
					low_q  <= low_nxt;
					high_q <= high_nxt;
				end
			end
			if (cmd_pop && cmd.last) begin
				fin_valid_s2 <= 1'b1;
			end else if (res_push) begin
				fin_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.last) begin
			fin_low_s2  <= low_fold;
			fin_high_s2 <= high_fold;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && cmd.last) |=> fin_valid_s2)
		else $error("final stage not loaded after the last word");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && cmd.last) |=> (low_q == SUM_INIT && high_q == SUM_INIT))
		else $error("sums not restarted after the last word");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fin_valid_s2 && res_full) |-> !cmd_pop)
		else $error("word taken while the final stage is held");

endmodule

`default_nettype wire

// ===== hdl/fletcher32_byte_checksum.sv =====
// path: byte queue, accumulator final stage, result queue, then the pop
// throughput: one byte per cycle while the result queue has room, set by the
// accumulator's sum and fold loop; byte and result queues decouple both sides
// reset: arst_n clears the queues, the block count and both sums to 0xffff
`timescale 1ns / 1ps
`default_nettype none

module fletcher32_byte_checksum #(
	parameter int unsigned BLOCK_BYTES = 360,
	parameter int unsigned CMD_DEPTH   = 4,
	parameter int unsigned RES_DEPTH   = 2
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  push,
	output logic                                       full,
	input  wire logic [fl32cs_pkg::BYTE_W-1:0]         data_byte,
	input  wire logic                                  last_byte,
	output logic                                       empty,
	input  wire logic                                  pop,
	output logic [fl32cs_pkg::CHECKSUM_W-1:0]          checksum
);

	import fl32cs_pkg::*;

	cmd_t                  front_cmd;
	cmd_t                  back_cmd;
	logic                  cmd_push;
	logic                  cmd_full;
	logic                  cmd_pop;
	logic                  cmd_empty;
	logic                  res_push;
	logic                  res_full;
	logic [CHECKSUM_W-1:0] res_data;

	fl32cs_front #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.cmd_push  (cmd_push),
		.cmd       (front_cmd),
		.cmd_full  (cmd_full)
	);

	fl32cs_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (front_cmd),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (back_cmd),
		.empty   (cmd_empty)
	);

	fl32cs_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res_data  (res_data),
		.res_full  (res_full)
	);

	fl32cs_fifo #(
		.WIDTH(CHECKSUM_W),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (checksum),
		.empty   (empty)
	);

endmodule

`default_nettype wire

// ===== bench/fletcher32_byte_checksum_test.sv =====
`timescale 1ns / 1ps

module fletcher32_byte_checksum_test;

	import fl32cs_pkg::*;

	localparam int unsigned BLOCK_BYTES = 360;
	localparam int unsigned DIR_ROWS    = 9;
	localparam int unsigned RAND_MSGS   = 16;
	localparam int unsigned CALM_MSGS   = 10;

	typedef struct packed {
		logic [9:0]            len;
		logic [BYTE_W-1:0]     fill;
		logic                  rnd;
		logic                  typed;
		logic [CHECKSUM_W-1:0] sum;
	} msg_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	logic [BYTE_W-1:0]     data_byte = '0;
	logic                  last_byte = 1'b0;
	logic                  empty;
	logic                  pop       = 1'b0;
	logic [CHECKSUM_W-1:0] checksum;

	logic [SUM_W-1:0]      run_low   = SUM_INIT;
	logic [SUM_W-1:0]      run_high  = SUM_INIT;
	logic [8:0]            run_count = '0;
	logic [CHECKSUM_W-1:0] pending_checksums [$];
	logic [CHECKSUM_W-1:0] want;

	msg_row_t    dir_rows [0:DIR_ROWS-1];
	bit          calm       = 1'b0;
	int unsigned gap_rate   = 0;
	int unsigned stall_rate = 2;
	int unsigned n_msgs     = 0;
	int unsigned n_bytes    = 0;
	int unsigned n_checked  = 0;
	int unsigned errors     = 0;

	fletcher32_byte_checksum dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.empty     (empty),
		.pop       (pop),
		.checksum  (checksum)
	);

	always #5 clk = ~clk;

	function automatic logic [SUM_W-1:0] fold16(input logic [SUM_W-1:0] v);
		return (v & 32'h0000_ffff) + (v >> HALF_W);
	endfunction

	task automatic fletcher_add_byte(input logic [BYTE_W-1:0] b, input logic l,
			output logic [CHECKSUM_W-1:0] cs);
		run_low   = run_low + SUM_W'(b);
		run_high  = run_high + run_low;
		run_count = run_count + 9'd1;
		if (run_count >= BLOCK_BYTES || l) begin
			run_low   = fold16(run_low);
			run_high  = fold16(run_high);
			run_count = '0;
		end
		cs = '0;
		if (l) begin
			run_low   = fold16(run_low);
			run_high  = fold16(run_high);
			cs        = (run_high << HALF_W) | run_low;
			run_low   = SUM_INIT;
			run_high  = SUM_INIT;
			run_count = '0;
		end
	endtask

	task automatic put_byte(input logic [BYTE_W-1:0] b, input logic l, input logic typed,
			input logic [CHECKSUM_W-1:0] typed_sum);
		logic [CHECKSUM_W-1:0] cs;
		if (gap_rate != 0 && $urandom_range(0, 7) < gap_rate) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		// hold the word until it is taken
		push      <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		do @(posedge clk); while (full);
		n_bytes++;
		fletcher_add_byte(b, l, cs);
		if (l) begin
			pending_checksums.push_back(typed ? typed_sum : cs);
			n_msgs++;
		end
	endtask

	task automatic send_msg(input msg_row_t row);
		logic [BYTE_W-1:0] b;
		gap_rate = calm ? 0 : $urandom_range(0, 3);
		for (int unsigned i = 0; i < row.len; i++) begin
			b = row.rnd ? BYTE_W'($urandom_range(0, 255)) : row.fill;
			put_byte(b, i == row.len - 1, row.typed, row.sum);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_checksums.size() == 0) begin
				$display("%0t unexpected checksum: expected none, got %h", $time, checksum);
				errors++;
			end else begin
				want = pending_checksums.pop_front();
				if (checksum !== want) begin
					$display("%0t checksum mismatch: expected %h, got %h",
						$time, want, checksum);
					errors++;
				end
				n_checked++;
			end
		end
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!calm && stall_rate != 0 && $urandom_range(0, 15) < stall_rate) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			pop <= 1'b1;
			if ($urandom_range(0, 63) == 0)
				stall_rate = $urandom_range(0, 4);
		end
	end

	initial begin
		#5_000_000;
		$display("fletcher32_byte_checksum test failed");
		$finish;
	end

	initial begin
		msg_row_t    row;
		int unsigned pick;
		int unsigned rand_msgs;

		// single bytes, fill extremes, block edges around the last byte
		dir_rows[0]  = '{len: 10'd1,   fill: 8'h00, rnd: 1'b0, typed: 1'b1, sum: 32'hffff_ffff};
		dir_rows[1]  = '{len: 10'd1,   fill: 8'hff, rnd: 1'b0, typed: 1'b1, sum: 32'h00ff_00ff};
		dir_rows[2]  = '{len: 10'd1,   fill: 8'h01, rnd: 1'b0, typed: 1'b1, sum: 32'h0001_0001};
		dir_rows[3]  = '{len: 10'd2,   fill: 8'h00, rnd: 1'b0, typed: 1'b0, sum: '0};
		dir_rows[4]  = '{len: 10'd2,   fill: 8'hff, rnd: 1'b0, typed: 1'b0, sum: '0};
		dir_rows[5]  = '{len: 10'd16,  fill: 8'h00, rnd: 1'b1, typed: 1'b0, sum: '0};
		dir_rows[6]  = '{len: 10'd360, fill: 8'hff, rnd: 1'b0, typed: 1'b0, sum: '0};
		dir_rows[7]  = '{len: 10'd361, fill: 8'h00, rnd: 1'b1, typed: 1'b0, sum: '0};
		dir_rows[8]  = '{len: 10'd3,   fill: 8'h00, rnd: 1'b1, typed: 1'b0, sum: '0};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned r = 0; r < DIR_ROWS; r++)
			send_msg(dir_rows[r]);

		rand_msgs = 0;
		while (rand_msgs < RAND_MSGS) begin
			pick = $urandom_range(0, 99);
			row  = '{len: 10'd1, fill: 8'h00, rnd: 1'b1, typed: 1'b0, sum: '0};
			if (pick < 80)
				row.len = 10'($urandom_range(1, 8));
			else
				row.len = 10'($urandom_range(9, 24));
			calm = rand_msgs >= CALM_MSGS;
			send_msg(row);
			rand_msgs++;
		end
		push      <= 1'b0;
		last_byte <= 1'b0;

		while (pending_checksums.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);

		$display("%0d messages of %0d bytes sent, %0d checksums compared,", n_msgs, n_bytes,
			n_checked);
		$display("including messages ending on and across 360-byte block edges");
		if (errors == 0)
			$display("fletcher32_byte_checksum test passed");
		else
			$display("fletcher32_byte_checksum test failed");
		$finish;
	end

endmodule
